// File: hw/rtl/atb_pkg.sv
// ----------------------------------------------------------------------------
// atb_pkg: shared constants for the adaptive threshold binarizer
// Field widths, fixed-point formats, register map and output levels.
// ----------------------------------------------------------------------------
package atb_pkg;

	// pixel item fields
	localparam int PIX_W   = 8;
	localparam int COL_W   = 12;

	// fixed-point formats
	localparam int FRAC_BITS  = 8;
	localparam int SUM_W      = 18 + FRAC_BITS;
	localparam int RELAX_FRAC = 8;

	// line store geometry
	localparam int MAX_WIDTH = 4096;
	localparam int LINE_AW   = $clog2(MAX_WIDTH);

	// configuration registers
	localparam int WIN_W   = 11;
	localparam int RELAX_W = 10;
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam int REG_IDX_W = PADDR_W - 2;

	localparam logic [REG_IDX_W-1:0] REG_WINDOW = REG_IDX_W'(0);
	localparam logic [REG_IDX_W-1:0] REG_RELAX  = REG_IDX_W'(1);

	localparam logic [WIN_W-1:0]   WINDOW_RESET = WIN_W'(160);
	localparam logic [RELAX_W-1:0] RELAX_RESET  = RELAX_W'(256);

	// output levels
	localparam logic [PIX_W-1:0] PIX_FG = PIX_W'(255);
	localparam logic [PIX_W-1:0] PIX_BG = PIX_W'(0);

endpackage

// File: hw/rtl/atb_pixel_if.sv
// ----------------------------------------------------------------------------
// atb_pixel_if: grey pixel channel
// Valid/ready channel carrying one pixel with its column and frame markers.
// ----------------------------------------------------------------------------
interface atb_pixel_if;
	logic                        valid;
	logic                        ready;
	logic [atb_pkg::PIX_W-1:0]   pixel;
	logic [atb_pkg::COL_W-1:0]   column;
	logic                        frame_start;
	logic                        first_row;

	modport source (output valid, output pixel, output column, output frame_start,
		output first_row, input ready);
	modport sink (input valid, input pixel, input column, input frame_start,
		input first_row, output ready);
endinterface

// File: hw/rtl/atb_result_if.sv
// ----------------------------------------------------------------------------
// atb_result_if: binarized pixel channel
// Valid/ready channel carrying one binarized pixel.
// ----------------------------------------------------------------------------
interface atb_result_if;
	logic                        valid;
	logic                        ready;
	logic [atb_pkg::PIX_W-1:0]   out_pixel;

	modport source (output valid, output out_pixel, input ready);
	modport sink (input valid, input out_pixel, output ready);
endinterface

// File: hw/rtl/adaptive_threshold_binarizer_unit.sv
// ----------------------------------------------------------------------------
// adaptive_threshold_binarizer_unit: running-average pixel binarizer
// Keeps a running window sum S = S - S/W + p over a serpentine scan and marks
// a pixel foreground when p >= ((line[col] + S) / 2 / W) * relax.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake         payload
//  --------  ---  ----------------  ----------------------------------------
//  gray      in   valid / ready     pixel, column, frame_start, first_row
//  binary    out  valid / ready     out_pixel (255 or 0)
//  apb       cfg  psel/penable      window_len @0x0, relax_factor @0x4
//
//  Each pixel passes an accept step, SUM_W restoring divider steps for
//  S / W, then update, multiply and compare/write-back steps; the next pixel
//  is taken only after that. Reset clears S and the control state, not the
//  line store: the user must see that an entry is only read after its column
//  was written in an earlier row, which the block itself does not enforce.
//  A stalled binary channel holds the finished pixel in the compare state;
//  gray.ready stays low until the result is transferred into the output register.
// ----------------------------------------------------------------------------
module adaptive_threshold_binarizer_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [atb_pkg::PADDR_W-1:0]   paddr,
	input  logic [atb_pkg::PDATA_W-1:0]   pwdata,
	output logic [atb_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready,
	// data channels
	atb_pixel_if.sink                     gray,
	atb_result_if.source                  binary
);

	localparam int CNT_W  = $clog2(atb_pkg::SUM_W);
	localparam int PW_W   = atb_pkg::PIX_W + atb_pkg::WIN_W;
	localparam int ACC_W  = atb_pkg::SUM_W + 1;
	localparam int RHS_W  = ACC_W + atb_pkg::RELAX_W;
	localparam int CMP_W  = RHS_W + 1;
	// p * 2 * W scaled into the same units as (line + S) * relax
	localparam int LHS_SH = 1 + atb_pkg::FRAC_BITS + atb_pkg::RELAX_FRAC;
	localparam logic [atb_pkg::SUM_W-1:0] SUM_MAX = '1;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_DIV  = 5'b00010,
		ST_SUM  = 5'b00100,
		ST_MUL  = 5'b01000,
		ST_DONE = 5'b10000
	} state_t;

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic [atb_pkg::WIN_W-1:0]     window_len_q;
	logic [atb_pkg::RELAX_W-1:0]   relax_factor_q;
	logic [atb_pkg::REG_IDX_W-1:0] reg_idx;
	logic                          cfg_wr;

	assign pready  = 1'b1;
	assign reg_idx = paddr[atb_pkg::PADDR_W-1:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_len_q   <= atb_pkg::WINDOW_RESET;
			relax_factor_q <= atb_pkg::RELAX_RESET;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				atb_pkg::REG_WINDOW: window_len_q   <= pwdata[atb_pkg::WIN_W-1:0];
				atb_pkg::REG_RELAX:  relax_factor_q <= pwdata[atb_pkg::RELAX_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			atb_pkg::REG_WINDOW: prdata = atb_pkg::PDATA_W'(window_len_q);
			atb_pkg::REG_RELAX:  prdata = atb_pkg::PDATA_W'(relax_factor_q);
			default:             prdata = '0;
		endcase
	end

	// a zero window behaves as a window of one
	logic [atb_pkg::WIN_W-1:0] w_eff;
	assign w_eff = (window_len_q == '0) ? atb_pkg::WIN_W'(1) : window_len_q;

	// ------------------------------------------------------------------
	// Sequencer and datapath registers
	// ------------------------------------------------------------------
	state_t                         state_q;
	logic [CNT_W-1:0]               cnt_q;
	logic [atb_pkg::SUM_W-1:0]      sum_q;      // running sum S
	logic [atb_pkg::SUM_W-1:0]      base_q;     // S before this pixel's update
	logic [atb_pkg::SUM_W-1:0]      div_q;      // dividend in, quotient out
	logic [atb_pkg::WIN_W-1:0]      rem_q;
	logic [atb_pkg::SUM_W-1:0]      new_sum_q;
	logic [atb_pkg::PIX_W-1:0]      pix_q;
	logic [atb_pkg::LINE_AW-1:0]    addr_q;
	logic                           col_ok_q;
	logic                           first_q;
	logic [PW_W-1:0]                lhs_q;
	logic [RHS_W-1:0]               rhs_q;
	logic                           out_valid_q;
	logic [atb_pkg::PIX_W-1:0]      out_pix_q;

	logic                           in_xfer;
	logic                           out_free;
	logic                           done_load;
	logic [atb_pkg::WIN_W:0]        rem_sh;
	logic                           rem_ge;
	logic [ACC_W-1:0]               sum_full;
	logic [atb_pkg::SUM_W-1:0]      line_rd;
	logic [atb_pkg::SUM_W-1:0]      line_val;
	logic [ACC_W-1:0]               line_plus_s;
	logic [CMP_W-1:0]               lhs_cmp;
	logic                           col_ok_in;

	assign gray.ready = (state_q == ST_IDLE);
	assign in_xfer    = gray.valid && gray.ready;
	assign out_free   = !out_valid_q || binary.ready;
	assign done_load  = (state_q == ST_DONE) && out_free;
	assign col_ok_in  = 32'(gray.column) < atb_pkg::MAX_WIDTH;

	// restoring divider step: shift one dividend bit into the remainder
	assign rem_sh = {rem_q, div_q[atb_pkg::SUM_W-1]};
	assign rem_ge = rem_sh >= {1'b0, w_eff};

	// S - floor(S / W) + p, saturated to the sum width
	assign sum_full = {1'b0, base_q} - {1'b0, div_q}
		+ (ACC_W'(pix_q) << atb_pkg::FRAC_BITS);

	// previous row's sum, or zero on the first row or past the line store
	assign line_val    = (first_q || !col_ok_q) ? '0 : line_rd;
	assign line_plus_s = {1'b0, line_val} + {1'b0, new_sum_q};
	assign lhs_cmp     = CMP_W'(lhs_q) << LHS_SH;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			sum_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// refill the output with a finished pixel, else drop it once taken
			if (done_load) begin
				out_valid_q <= 1'b1;
			end else if (binary.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						cnt_q   <= '0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(atb_pkg::SUM_W - 1)) begin
						state_q <= ST_SUM;
					end
				end
				ST_SUM: begin
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					// hold here until the output register is free
					if (out_free) begin
						sum_q   <= new_sum_q;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					pix_q    <= gray.pixel;
					addr_q   <= atb_pkg::LINE_AW'(gray.column);
					col_ok_q <= col_ok_in;
					first_q  <= gray.first_row;
					// frame start clears S before the update
					base_q   <= gray.frame_start ? '0 : sum_q;
					div_q    <= gray.frame_start ? '0 : sum_q;
					rem_q    <= '0;
				end
			end
			ST_DIV: begin
				rem_q <= rem_ge ? atb_pkg::WIN_W'(rem_sh - {1'b0, w_eff})
					: atb_pkg::WIN_W'(rem_sh);
				div_q <= {div_q[atb_pkg::SUM_W-2:0], rem_ge};
			end
			ST_SUM: begin
				new_sum_q <= sum_full[atb_pkg::SUM_W] ? SUM_MAX
					: sum_full[atb_pkg::SUM_W-1:0];
			end
			ST_MUL: begin
				lhs_q <= PW_W'(pix_q) * PW_W'(w_eff);
				rhs_q <= RHS_W'(line_plus_s) * RHS_W'(relax_factor_q);
			end
			ST_DONE: begin
				if (out_free) begin
					out_pix_q <= (lhs_cmp >= CMP_W'(rhs_q)) ? atb_pkg::PIX_FG
						: atb_pkg::PIX_BG;
				end
			end
			default: ;
		endcase
	end

	assign binary.valid     = out_valid_q;
	assign binary.out_pixel = out_pix_q;

	// ------------------------------------------------------------------
	// Line store: read on accept, write back S once the result leaves
	// ------------------------------------------------------------------
	atb_ram #(
		.WIDTH (atb_pkg::SUM_W),
		.DEPTH (atb_pkg::MAX_WIDTH)
	) u_line (
		.clk   (clk),
		.we    (done_load && col_ok_q),
		.waddr (addr_q),
		.wdata (new_sum_q),
		.re    (in_xfer),
		.raddr (atb_pkg::LINE_AW'(gray.column)),
		.rdata (line_rd)
	);

endmodule

// File: hw/rtl/atb_ram.sv
// ----------------------------------------------------------------------------
// atb_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module atb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench: adaptive threshold binarizer unit
// Drives serpentine pixel frames through the gray channel under random
// idling, back pressure and a long receiver hold-off. It predicts every
// binarized pixel with an in-line fixed-point running-sum model and compares
// the results in order. Register settings cover the zero window, an oversized
// window, relax extremes and random points, and change only while idle.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import atb_pkg::*;

	// quiet cycles tolerated before declaring a hang: well above one pixel's
	// processing plus the receiver hold-off below
	localparam int STALL_LIMIT     = 2000;
	localparam int HOLD_OFF_CYCLES = 300;
	// settle time after the last result, derived from the pixel time with margin
	localparam int DRAIN_CYCLES    = 2 * (SUM_W + 4) + 4;
	localparam logic [63:0] SUM_LIMIT = (64'd1 << SUM_W) - 64'd1;
	localparam int BRIGHT_ROW_LEN  = 40;

	typedef struct packed {
		logic [PIX_W-1:0] pixel;
		logic [COL_W-1:0] column;
		logic             frame_start;
		logic             first_row;
	} gray_item_t;

	logic clk = 1'b0;
	logic arst_n;

	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	atb_pixel_if  gray_ch();
	atb_result_if binary_ch();

	adaptive_threshold_binarizer_unit dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.gray    (gray_ch),
		.binary  (binary_ch)
	);

	always #2ns clk = ~clk;

	// ------------------------------------------------------------------------
	// Threshold predictor state: register copies, running sum, line sums.
	// ------------------------------------------------------------------------
	logic [WIN_W-1:0]   win_len_q;
	logic [RELAX_W-1:0] relax_q;
	logic [SUM_W-1:0]   win_sum;
	logic [SUM_W-1:0]   row_sums [MAX_WIDTH];
	// columns whose line entry has been written by some queued pixel
	bit                 filled [MAX_WIDTH];

	gray_item_t       pending_pixels [$];
	logic [PIX_W-1:0] expected_levels [$];

	int errors       = 0;
	int queued_total = 0;
	int accepted     = 0;
	int compared     = 0;
	int saturated    = 0;
	int foreground   = 0;
	int settings_run = 0;
	int quiet_cycles = 0;

	// steady: no random idling on either side; squeeze_req: ask the
	// receiver for one long hold-off
	bit steady      = 1'b0;
	int squeeze_req = 0;

	// Advance the running sum for one pixel, update the line entry and
	// return the binarized level.
	function automatic logic [PIX_W-1:0] binarize(input gray_item_t it);
		logic [63:0] w;
		logic [63:0] acc;
		logic [63:0] line_val;
		logic [63:0] lhs;
		logic [63:0] rhs;
		// a zero window behaves as a window of one
		w = (win_len_q == '0) ? 64'd1 : 64'(win_len_q);
		if (it.frame_start)
			win_sum = '0;
		acc = 64'(win_sum) - 64'(win_sum) / w + (64'(it.pixel) << FRAC_BITS);
		// clip the sum at the top of its fixed-point range
		if (acc > SUM_LIMIT) begin
			acc = SUM_LIMIT;
			saturated++;
		end
		win_sum = acc[SUM_W-1:0];
		line_val = '0;
		if (!it.first_row && it.column < MAX_WIDTH)
			line_val = 64'(row_sums[it.column]);
		// exact compare: p >= ((line + S) / 2 / W) * relax, scaled to integers
		lhs = ((64'(it.pixel) * 64'd2 * w) << FRAC_BITS) << RELAX_FRAC;
		rhs = (line_val + acc) * 64'(relax_q);
		if (it.column < MAX_WIDTH)
			row_sums[it.column] = acc[SUM_W-1:0];
		return (lhs >= rhs) ? PIX_FG : PIX_BG;
	endfunction

	// Queue one pixel. Force first_row on a column that nothing wrote yet,
	// so the block never uses an undefined line entry.
	function automatic void push_pixel(input logic [PIX_W-1:0] pix,
		input logic [COL_W-1:0] col, input logic fs, input logic first);
		gray_item_t it;
		it.pixel       = pix;
		it.column      = col;
		it.frame_start = fs;
		it.first_row   = first || !filled[col];
		filled[col] = 1'b1;
		pending_pixels.push_back(it);
		queued_total++;
	endfunction

	// One small serpentine frame at a random column offset, with scattered
	// noise pixels, stray frame starts and stray first-row marks.
	task automatic add_frame();
		int width;
		int rows;
		int base;
		int col;
		width = $urandom_range(20, 2);
		rows  = $urandom_range(5, 2);
		base  = $urandom_range(MAX_WIDTH - width, 0);
		for (int r = 0; r < rows; r++) begin
			for (int k = 0; k < width; k++) begin
				if ($urandom_range(99) < 8)
					push_pixel(PIX_W'($urandom), COL_W'($urandom), 1'($urandom),
						1'($urandom));
				col = (r % 2 == 0) ? base + k : base + width - 1 - k;
				push_pixel(PIX_W'($urandom), COL_W'(col),
					(r == 0 && k == 0) || $urandom_range(99) < 2,
					r == 0 || $urandom_range(99) < 3);
			end
		end
	endtask

	task automatic add_frames(input int count);
		int goal;
		goal = queued_total + count;
		while (queued_total < goal)
			add_frame();
	endtask

	// APB write: setup cycle, then access cycle; the register takes the
	// value at the edge that ends the access cycle.
	task automatic apb_write(input logic [REG_IDX_W-1:0] idx, input logic [PDATA_W-1:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= PADDR_W'({idx, 2'b00});
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic program_regs(input logic [WIN_W-1:0] w, input logic [RELAX_W-1:0] r);
		apb_write(REG_WINDOW, PDATA_W'(w));
		win_len_q = w;
		apb_write(REG_RELAX, PDATA_W'(r));
		relax_q = r;
		settings_run++;
	endtask

	// Hold until every queued pixel is transferred and every result is back.
	task automatic wait_idle();
		while (pending_pixels.size() != 0 || gray_ch.valid || expected_levels.size() != 0)
			@(posedge clk);
	endtask

	// ------------------------------------------------------------------------
	// Pixel driver: on a transfer, predict its result; then offer the next
	// queued pixel unless this cycle idles.
	// ------------------------------------------------------------------------
	gray_item_t offered;
	gray_item_t taken;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gray_ch.valid       <= 1'b0;
			gray_ch.pixel       <= '0;
			gray_ch.column      <= '0;
			gray_ch.frame_start <= 1'b0;
			gray_ch.first_row   <= 1'b0;
		end else begin
			if (gray_ch.valid && gray_ch.ready) begin
				taken.pixel       = gray_ch.pixel;
				taken.column      = gray_ch.column;
				taken.frame_start = gray_ch.frame_start;
				taken.first_row   = gray_ch.first_row;
				expected_levels.push_back(binarize(taken));
				accepted++;
			end
			// a held pixel stays on the bus until it is transferred
			if (!gray_ch.valid || gray_ch.ready) begin
				if (pending_pixels.size() != 0 && (steady || $urandom_range(99) >= 6)) begin
					offered = pending_pixels.pop_front();
					gray_ch.valid       <= 1'b1;
					gray_ch.pixel       <= offered.pixel;
					gray_ch.column      <= offered.column;
					gray_ch.frame_start <= offered.frame_start;
					gray_ch.first_row   <= offered.first_row;
				end else begin
					gray_ch.valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Result monitor: compare each transfer with the oldest expectation, and
	// drive ready with random stalls and the requested long hold-off.
	// ------------------------------------------------------------------------
	logic [PIX_W-1:0] want;
	int               hold_left     = 0;
	int               squeezes_done = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			binary_ch.ready <= 1'b0;
		end else begin
			if (binary_ch.valid && binary_ch.ready) begin
				if (expected_levels.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual out_pixel=%0d",
						$time, binary_ch.out_pixel);
					errors++;
				end else begin
					want = expected_levels.pop_front();
					if (binary_ch.out_pixel !== want) begin
						$display("%0t: out_pixel mismatch, expected %0d, actual %0d",
							$time, want, binary_ch.out_pixel);
						errors++;
					end
				end
				compared++;
				if (binary_ch.out_pixel == PIX_FG)
					foreground++;
			end
			if (squeeze_req != squeezes_done) begin
				hold_left     = HOLD_OFF_CYCLES;
				squeezes_done = squeeze_req;
			end
			if (hold_left > 0) begin
				hold_left--;
				binary_ch.ready <= 1'b0;
			end else begin
				binary_ch.ready <= steady || $urandom_range(99) >= 6;
			end
		end
	end

	// Watchdog: end the run when nothing moves on either channel for too long.
	always @(posedge clk) begin
		if (arst_n !== 1'b1 || (gray_ch.valid && gray_ch.ready)
			|| (binary_ch.valid && binary_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
			$display("testbench failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// ------------------------------------------------------------------------
	// Sequence: reset, directed pixels, then register phases with random
	// frames. Registers change only once the block has drained.
	// ------------------------------------------------------------------------
	initial begin
		arst_n              = 1'b0;
		psel                = 1'b0;
		penable             = 1'b0;
		pwrite              = 1'b0;
		paddr               = '0;
		pwdata              = '0;
		gray_ch.valid       = 1'b0;
		gray_ch.pixel       = '0;
		gray_ch.column      = '0;
		gray_ch.frame_start = 1'b0;
		gray_ch.first_row   = 1'b0;
		binary_ch.ready     = 1'b0;
		win_len_q           = WINDOW_RESET;
		relax_q             = RELAX_RESET;
		win_sum             = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: a tiny frame on the top columns with extreme pixels,
		// a frame start in the middle of a row, then single first-row
		// pixels that walk the column bits.
		program_regs(WINDOW_RESET, RELAX_RESET);
		push_pixel(8'd255, 12'd4092, 1'b1, 1'b1);
		push_pixel(8'd0,   12'd4093, 1'b0, 1'b1);
		push_pixel(8'd255, 12'd4094, 1'b0, 1'b1);
		push_pixel(8'd0,   12'd4095, 1'b0, 1'b1);
		push_pixel(8'd0,   12'd4095, 1'b0, 1'b0);
		push_pixel(8'd255, 12'd4094, 1'b0, 1'b0);
		push_pixel(8'd128, 12'd4093, 1'b0, 1'b0);
		push_pixel(8'd1,   12'd4092, 1'b0, 1'b0);
		push_pixel(8'd200, 12'd4092, 1'b0, 1'b0);
		push_pixel(8'd200, 12'd4093, 1'b1, 1'b0);
		push_pixel(8'd10,  12'd4094, 1'b0, 1'b0);
		push_pixel(8'd254, 12'd4095, 1'b0, 1'b0);
		push_pixel(8'd127, 12'h800,  1'b0, 1'b1);
		push_pixel(8'd64,  12'h001,  1'b0, 1'b1);
		push_pixel(8'd32,  12'hAAA,  1'b0, 1'b1);
		push_pixel(8'd16,  12'h555,  1'b0, 1'b1);
		push_pixel(8'd0,   12'h000,  1'b0, 1'b1);
		wait_idle();

		// smallest window and zero relax: every pixel is foreground
		program_regs(WIN_W'(1), RELAX_W'(0));
		add_frames(30);
		wait_idle();

		// large window and largest relax; receiver holds off at the start
		// while the driver keeps offering, so the input side backs up
		program_regs(WIN_W'(1024), RELAX_W'(1023));
		squeeze_req++;
		add_frames(60);
		wait_idle();

		// zero window, run without idling on either side
		steady = 1'b1;
		program_regs(WIN_W'(0), RELAX_W'(256));
		add_frames(80);
		wait_idle();
		steady = 1'b0;

		// widest window: a run of bright pixels on a fresh frame
		program_regs(WIN_W'(2047), RELAX_W'(1023));
		for (int k = 0; k < BRIGHT_ROW_LEN; k++)
			push_pixel(PIX_FG, COL_W'(k), k == 0, 1'b1);
		add_frames(20);
		wait_idle();

		repeat (4) begin
			program_regs(WIN_W'($urandom_range(1024, 1)), RELAX_W'($urandom_range(1023, 0)));
			add_frames(40);
			wait_idle();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_levels.size() != 0) begin
			$display("%0t: %0d expected results never arrived", $time, expected_levels.size());
			errors++;
		end

		$display("covered %0d pixels over %0d register settings, %0d results compared",
			accepted, settings_run, compared);
		$display("window sum clipped on %0d pixels, %0d foreground results",
			saturated, foreground);
		if (errors == 0) begin
			$display("testbench passed");
		end else begin
			$display("testbench failed");
		end
		$finish;
	end

endmodule
